// ===== rtl/esc_pkg.sv =====
// Shared constants, types and tables for the epoch-seconds to calendar-date block.
// No dependencies; every other file of the block imports this package.
package esc_pkg;

  localparam int SECONDS_WIDTH = 32;

  localparam int unsigned EPOCH_YEAR      = 1970;
  localparam int unsigned DAYS_PER_CYCLE  = 146097;
  localparam int unsigned YEARS_PER_CYCLE = 400;
  localparam int unsigned DAYS_COMMON     = 365;
  localparam int unsigned DAYS_LEAP       = 366;
  localparam int unsigned EPOCH_WEEKDAY   = 4;  // The epoch day is a Thursday.
  localparam int unsigned SEC_PER_MIN     = 60;
  localparam int unsigned SEC_PER_HOUR    = 3600;

  // A day of 86400 seconds is 2^7 times 675.
  localparam int          DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD   = 675;

  // Widths of the result fields.
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // Internal widths that follow from the seconds width.
  localparam int REM_W   = $clog2(DAYS_PER_CYCLE);
  localparam int DAY_W   = $clog2(((64'd1 << SECONDS_WIDTH) / 64'd86400) + 64'd1);
  localparam int DWALK_W = (DAY_W > REM_W) ? DAY_W : REM_W;
  localparam int YR_W    = $clog2(((64'd1 << SECONDS_WIDTH) / 64'd31536000)
                                  + 64'd1 + 64'd1971);
  localparam int M100_W  = 7;
  localparam int M400_W  = 9;

  // Reciprocal constants: for x below 2^N and k = N + clog2(d), the product
  // x * ceil(2^k / d) shifted right by k is exactly x / d.
  localparam int U_W    = SECONDS_WIDTH - DAY_SHIFT;
  localparam int DREM_W = $clog2(DAY_ODD);
  localparam int DAY_K  = U_W + DREM_W;
  localparam longint unsigned DAY_MAGIC =
    ((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD);
  localparam int DAYM_W = $clog2(DAY_MAGIC + 64'd1);
  localparam int DAYP_W = U_W + DAYM_W;

  localparam int SOD_W  = DREM_W + DAY_SHIFT;
  localparam int HREM_W = $clog2(SEC_PER_HOUR);
  localparam int HOUR_K = SOD_W + HREM_W;
  localparam longint unsigned HOUR_MAGIC =
    ((64'd1 << HOUR_K) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR);
  localparam int HOURM_W = $clog2(HOUR_MAGIC + 64'd1);
  localparam int HOURP_W = SOD_W + HOURM_W;

  localparam int MIN_K = HREM_W + $clog2(SEC_PER_MIN);
  localparam longint unsigned MIN_MAGIC =
    ((64'd1 << MIN_K) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
  localparam int MINM_W = $clog2(MIN_MAGIC + 64'd1);
  localparam int MINP_W = HREM_W + MINM_W;

  localparam int unsigned EPOCH_MOD100 = EPOCH_YEAR % 100;
  localparam int unsigned EPOCH_MOD400 = EPOCH_YEAR % 400;
  localparam int unsigned LAST_MONTH   = 11;

  // Steps that split the seconds count into days and time of day.
  typedef enum logic [2:0] {
    OP_DAYS,
    OP_SOD,
    OP_HOUR,
    OP_HREM,
    OP_MIN,
    OP_SEC
  } split_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      split;
    split_op_t op;
    logic      cycle_step;
    logic      year_step;
    logic      month_step;
    logic      finish;
  } esc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cycle_fit;
    logic year_fit;
    logic month_fit;
  } esc_sts_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
    logic [4:0] n;
    case (m)
      4'd0:    n = 5'd31;
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd30;
      4'd4:    n = 5'd31;
      4'd5:    n = 5'd30;
      4'd6:    n = 5'd31;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd30;
      4'd9:    n = 5'd31;
      4'd10:   n = 5'd30;
      4'd11:   n = 5'd31;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Advances a weekday by up to 31 days.
  function automatic logic [WDAY_W-1:0] wday_add(input logic [WDAY_W-1:0] w,
                                                 input logic [MDAY_W-1:0] n);
    logic [5:0] s;
    s = 6'(w) + 6'(n);
    if (s >= 6'd28) s = s - 6'd28;
    if (s >= 6'd14) s = s - 6'd14;
    if (s >= 6'd7)  s = s - 6'd7;
    return s[WDAY_W-1:0];
  endfunction

endpackage

// ===== rtl/esc_in_if.sv =====
// Input channel: valid/ready handshake carrying one seconds count per beat.
// Depends on esc_pkg.
interface esc_in_if;
  import esc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SECONDS_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== rtl/esc_out_if.sv =====
// Result channel: valid/ready handshake carrying one calendar date per beat.
// Depends on esc_pkg.
interface esc_out_if;
  import esc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month_index;
  logic [MDAY_W-1:0]  day_of_month;
  logic [HOUR_W-1:0]  hour_of_day;
  logic [MIN_W-1:0]   minute_of_hour;
  logic [SEC_W-1:0]   second_of_minute;
  logic [WDAY_W-1:0]  weekday;

  modport source (output valid, output year, output month_index, output day_of_month,
                  output hour_of_day, output minute_of_hour, output second_of_minute,
                  output weekday, input ready);
  modport sink   (input valid, input year, input month_index, input day_of_month,
                  input hour_of_day, input minute_of_hour, input second_of_minute,
                  input weekday, output ready);
endinterface

// ===== rtl/esc_datapath.sv =====
// Datapath: reciprocal-multiply splits of the seconds count, year and month walkers,
// result register. Depends on esc_pkg; driven by esc_ctrl through esc_cmd_t.
module esc_datapath (
  input  logic                              clk,
  input  logic [esc_pkg::SECONDS_WIDTH-1:0] epoch_seconds,
  input  esc_pkg::esc_cmd_t                 cmd,
  output esc_pkg::esc_sts_t                 sts,
  output logic [esc_pkg::YEAR_W-1:0]        year,
  output logic [esc_pkg::MONTH_W-1:0]       month_index,
  output logic [esc_pkg::MDAY_W-1:0]        day_of_month,
  output logic [esc_pkg::HOUR_W-1:0]        hour_of_day,
  output logic [esc_pkg::MIN_W-1:0]         minute_of_hour,
  output logic [esc_pkg::SEC_W-1:0]         second_of_minute,
  output logic [esc_pkg::WDAY_W-1:0]        weekday
);
  import esc_pkg::*;

  logic [SECONDS_WIDTH-1:0] t_r;
  logic [SOD_W-1:0]         sod_r;
  logic [HREM_W-1:0]        hrem_r;
  logic [SEC_W-1:0]         sec_r;
  logic [MIN_W-1:0]         min_r;
  logic [HOUR_W-1:0]        hour_r;
  logic [WDAY_W-1:0]        wday_r;
  logic [DWALK_W-1:0]       days_r;
  logic [YR_W-1:0]          yr_r;
  logic [M100_W-1:0]        m100_r;
  logic [M400_W-1:0]        m400_r;
  logic [MONTH_W-1:0]       mon_r;

  logic [YEAR_W-1:0]  o_year_r;
  logic [MONTH_W-1:0] o_month_r;
  logic [MDAY_W-1:0]  o_mday_r;
  logic [HOUR_W-1:0]  o_hour_r;
  logic [MIN_W-1:0]   o_min_r;
  logic [SEC_W-1:0]   o_sec_r;
  logic [WDAY_W-1:0]  o_wday_r;

  logic [U_W-1:0]     u;
  logic [DAYP_W-1:0]  day_prod;
  logic [U_W-1:0]     day_rem;
  logic [HOURP_W-1:0] hour_prod;
  logic [MINP_W-1:0]  min_prod;
  logic               leap;
  logic [DWALK_W-1:0] ylen;
  logic [4:0]         mdays;
  logic [DWALK_W-1:0] mlen;

  // Whole days: the seconds count over 128, then over 675 by reciprocal multiply.
  assign u         = t_r[SECONDS_WIDTH-1:DAY_SHIFT];
  assign day_prod  = DAYP_W'(u) * DAYP_W'(DAY_MAGIC);
  assign day_rem   = u - U_W'(days_r) * U_W'(DAY_ODD);
  assign hour_prod = HOURP_W'(sod_r) * HOURP_W'(HOUR_MAGIC);
  assign min_prod  = MINP_W'(hrem_r) * MINP_W'(MIN_MAGIC);

  // The century counters follow the year, so no division by 100 or 400 is needed.
  assign leap  = (yr_r[1:0] == 2'd0) &&
                 ((m100_r != M100_W'(0)) || (m400_r == M400_W'(0)));
  assign ylen  = leap ? DWALK_W'(DAYS_LEAP) : DWALK_W'(DAYS_COMMON);
  assign mdays = month_len(leap, mon_r);
  assign mlen  = DWALK_W'(mdays);

  assign sts.cycle_fit = (days_r < DWALK_W'(DAYS_PER_CYCLE));
  assign sts.year_fit  = (days_r < ylen);
  assign sts.month_fit = (mon_r == MONTH_W'(LAST_MONTH)) || (days_r < mlen);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= epoch_seconds;
      yr_r   <= YR_W'(EPOCH_YEAR);
      m100_r <= M100_W'(EPOCH_MOD100);
      m400_r <= M400_W'(EPOCH_MOD400);
      mon_r  <= '0;
      wday_r <= WDAY_W'(EPOCH_WEEKDAY);
    end else if (cmd.split) begin
      case (cmd.op)
        OP_DAYS: begin
          days_r <= DWALK_W'(DAY_W'(day_prod >> DAY_K));
        end
        OP_SOD: begin
          sod_r <= {day_rem[DREM_W-1:0], t_r[DAY_SHIFT-1:0]};
        end
        OP_HOUR: begin
          hour_r <= HOUR_W'(hour_prod >> HOUR_K);
        end
        OP_HREM: begin
          hrem_r <= HREM_W'(sod_r - SOD_W'(hour_r) * SOD_W'(SEC_PER_HOUR));
        end
        OP_MIN: begin
          min_r <= MIN_W'(min_prod >> MIN_K);
        end
        OP_SEC: begin
          sec_r <= SEC_W'(hrem_r - HREM_W'(min_r) * HREM_W'(SEC_PER_MIN));
        end
        default: begin
        end
      endcase
    end else if (cmd.cycle_step) begin
      // A 400-year cycle is a whole number of weeks, so the weekday stays.
      days_r <= days_r - DWALK_W'(DAYS_PER_CYCLE);
      yr_r   <= yr_r + YR_W'(YEARS_PER_CYCLE);
    end else if (cmd.year_step) begin
      days_r <= days_r - ylen;
      yr_r   <= yr_r + YR_W'(1);
      m100_r <= (m100_r == M100_W'(99))  ? '0 : m100_r + M100_W'(1);
      m400_r <= (m400_r == M400_W'(399)) ? '0 : m400_r + M400_W'(1);
      wday_r <= wday_add(wday_r, leap ? MDAY_W'(2) : MDAY_W'(1));
    end else if (cmd.month_step) begin
      days_r <= days_r - mlen;
      mon_r  <= mon_r + MONTH_W'(1);
      wday_r <= wday_add(wday_r, mdays - MDAY_W'(28));
    end

    if (cmd.finish) begin
      o_year_r  <= yr_r[YEAR_W-1:0];
      o_month_r <= mon_r;
      o_mday_r  <= MDAY_W'(days_r) + MDAY_W'(1);
      o_hour_r  <= hour_r;
      o_min_r   <= min_r;
      o_sec_r   <= sec_r;
      o_wday_r  <= wday_add(wday_r, MDAY_W'(days_r));
    end
  end

  assign year             = o_year_r;
  assign month_index      = o_month_r;
  assign day_of_month     = o_mday_r;
  assign hour_of_day      = o_hour_r;
  assign minute_of_hour   = o_min_r;
  assign second_of_minute = o_sec_r;
  assign weekday          = o_wday_r;

endmodule

// ===== rtl/esc_ctrl.sv =====
// Controller: sequences the day and time splits, the 400-year cycle, year and month
// walks and the result beat. Depends on esc_pkg; drives esc_datapath through esc_cmd_t.
module esc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  esc_pkg::esc_sts_t sts,
  output esc_pkg::esc_cmd_t cmd
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_CYCLE,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_t;

  state_t    state_r, state_nxt;
  split_op_t op_r, op_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_DAYS;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        case (op_r)
          OP_DAYS: op_nxt = OP_SOD;
          OP_SOD:  op_nxt = OP_HOUR;
          OP_HOUR: op_nxt = OP_HREM;
          OP_HREM: op_nxt = OP_MIN;
          OP_MIN:  op_nxt = OP_SEC;
          OP_SEC:  state_nxt = ST_CYCLE;
          default: state_nxt = ST_CYCLE;
        endcase
      end
      ST_CYCLE: begin
        if (sts.cycle_fit) begin
          state_nxt = ST_YEAR;
        end else begin
          cmd.cycle_step = 1'b1;
        end
      end
      ST_YEAR: begin
        if (sts.year_fit) begin
          state_nxt = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_fit) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // The result register is reused only once its previous beat has left.
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_DAYS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/epoch_seconds_to_calendar_date.sv =====
// Top level of the seconds-since-epoch to UTC calendar date converter.
// Depends on esc_pkg, esc_in_if, esc_out_if, esc_ctrl and esc_datapath.
//
//   channel  | direction | payload per beat
//   ---------+-----------+-------------------------------------------------------
//   in_ch    | sink      | epoch_seconds
//   out_ch   | source    | year, month_index, day_of_month, hour_of_day,
//            |           | minute_of_hour, second_of_minute, weekday
//
// One item holds the block through the load, the day and time splits, the 400-year
// cycle walk (no whole cycle at 32 bits), the year walk (at most 136 years past the
// last 400-year boundary at 32 bits), the month walk up to the month index and the
// result write; a new input beat is taken only once the result has been written.
// Reset is synchronous and active low and clears only the control state.
// A new beat is taken while a finished result still waits on out_ch; a stalled result
// holds the block only when the next result is ready to be written.
module epoch_seconds_to_calendar_date (
  input logic clk,
  input logic rst_n,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);
  import esc_pkg::*;

  esc_cmd_t cmd;
  esc_sts_t sts;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  esc_datapath u_datapath (
    .clk              (clk),
    .epoch_seconds    (in_ch.epoch_seconds),
    .cmd              (cmd),
    .sts              (sts),
    .year             (out_ch.year),
    .month_index      (out_ch.month_index),
    .day_of_month     (out_ch.day_of_month),
    .hour_of_day      (out_ch.hour_of_day),
    .minute_of_hour   (out_ch.minute_of_hour),
    .second_of_minute (out_ch.second_of_minute),
    .weekday          (out_ch.weekday)
  );

endmodule

// ===== tb/epoch_seconds_to_calendar_date_tb.sv =====
// Testbench for the epoch-seconds to calendar-date converter: directed, random and
// back-pressure beats checked against a behavioral date calculation.
// Depends on esc_pkg, esc_in_if, esc_out_if and the epoch_seconds_to_calendar_date RTL.
module epoch_seconds_to_calendar_date_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int STALL_LIMIT  = 12000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_OFF     = 3000;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  wday;
  } calendar_date_t;

  typedef struct {
    logic [SECONDS_WIDTH-1:0] stamp;
    calendar_date_t           date;
  } pending_date_t;

  logic clk;
  logic rst_n;

  esc_in_if  in_ch();
  esc_out_if out_ch();

  epoch_seconds_to_calendar_date DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_date_t pending_dates[$];
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            hold_cycles    = 0;
  int            stamps_sent    = 0;
  int            dates_checked  = 0;
  int            mismatches     = 0;
  int            quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_leap(input longint unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Behavioral split of a seconds count into a UTC calendar date.
  function automatic calendar_date_t civil_date_of(input logic [SECONDS_WIDTH-1:0] secs);
    longint unsigned t;
    longint unsigned days;
    longint unsigned year;
    longint unsigned ylen;
    int unsigned     month;
    int unsigned     mlen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    calendar_date_t  d;
    t = secs;
    d.second = SEC_W'(t % 60);
    t = t / 60;
    d.minute = MIN_W'(t % 60);
    t = t / 60;
    d.hour = HOUR_W'(t % 24);
    days = t / 24;
    d.wday = WDAY_W'((days + EPOCH_WEEKDAY) % 7);
    year = EPOCH_YEAR + (days / DAYS_PER_CYCLE) * YEARS_PER_CYCLE;
    days = days % DAYS_PER_CYCLE;
    ylen = is_leap(year) ? DAYS_LEAP : DAYS_COMMON;
    while (days >= ylen) begin
      days = days - ylen;
      year = year + 1;
      ylen = is_leap(year) ? DAYS_LEAP : DAYS_COMMON;
    end
    if (is_leap(year)) begin
      mlen[1] = 29;
    end
    month = 0;
    while (month < LAST_MONTH && days >= mlen[month]) begin
      days = days - mlen[month];
      month = month + 1;
    end
    d.year  = YEAR_W'(year);
    d.month = MONTH_W'(month);
    d.mday  = MDAY_W'(days + 1);
    return d;
  endfunction

  // The driver holds valid across back-to-back beats; it drops it only for an idle gap and when results are drained.
  task automatic send_seconds(input logic [SECONDS_WIDTH-1:0] secs);
    pending_date_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.epoch_seconds <= secs;
    do @(posedge clk); while (!in_ch.ready);
    p.stamp = secs;
    p.date  = civil_date_of(secs);
    pending_dates.push_back(p);
    stamps_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SECONDS_WIDTH-1:0] random_seconds();
    longint unsigned v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom;
      // Day boundaries, where the date rolls over.
      5, 6: v = longint'($urandom_range(49710)) * 86400 + (($urandom_range(1)) ? 0 : 86399);
      7: v = $urandom_range(200000000);
      8: v = 64'hFFFF_FFFF - $urandom_range(100000000);
      default: v = 64'h8000_0000 + $urandom_range(1000000) - 500000;
    endcase
    return SECONDS_WIDTH'(v);
  endfunction

  task automatic check_field(input string name, input logic [SECONDS_WIDTH-1:0] secs,
                             input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch for %0d s: expected %0d, got %0d",
               $time, name, secs, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Result monitor: every beat on the output channel is matched to the oldest prediction.
  always @(posedge clk) begin
    pending_date_t p;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date beat %0d-%0d-%0d", $time, out_ch.year,
                 out_ch.month_index, out_ch.day_of_month);
        mismatches++;
      end else begin
        p = pending_dates.pop_front();
        check_field("year", p.stamp, 32'(p.date.year), 32'(out_ch.year));
        check_field("month_index", p.stamp, 32'(p.date.month), 32'(out_ch.month_index));
        check_field("day_of_month", p.stamp, 32'(p.date.mday), 32'(out_ch.day_of_month));
        check_field("hour_of_day", p.stamp, 32'(p.date.hour), 32'(out_ch.hour_of_day));
        check_field("minute_of_hour", p.stamp, 32'(p.date.minute),
                    32'(out_ch.minute_of_hour));
        check_field("second_of_minute", p.stamp, 32'(p.date.second),
                    32'(out_ch.second_of_minute));
        check_field("weekday", p.stamp, 32'(p.date.wday), 32'(out_ch.weekday));
        dates_checked++;
      end
    end
  end

  // Receiver: a long hold-off takes precedence over random stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    longint unsigned stamps [23] = '{
      0, 64'hFFFF_FFFF, 59, 3599, 86399, 86400,
      31449600,                   // last day of 1970
      31536000,                   // first day of 1971
      68169600 - 1,               // 1972-02-28, last second
      68169600,                   // leap day of 1972
      68169600 + 86400,           // 1972-03-01
      94694400 - 1,               // last second of a leap year
      94694400,
      946684800 - 1,              // end of 1999
      951782400,                  // leap day of a century divisible by 400
      951868800,
      978307200 - 1,              // last day of a leap century year
      64'h7FFF_FFFF, 64'h8000_0000,
      64'd47540 * 86400 + 86399,  // 2100-02-28: a century without a leap day
      64'd47541 * 86400,          // 2100-03-01
      64'hAAAA_AAAA, 64'h5555_5555
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (stamps[i]) begin
      send_seconds(SECONDS_WIDTH'(stamps[i]));
    end
    drain_results();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_seconds(random_seconds());
    end
    drain_results();
  endtask

  // The receiver holds off long enough for the block to fill and stop taking beats.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = HOLD_OFF;
    repeat (24) begin
      send_seconds(random_seconds());
    end
    drain_results();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.epoch_seconds = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 115);
    test_random(60, 0, 115);
    test_random(0, 60, 115);
    test_random(12, 12, 115);
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d timestamps (directed, random under four idle patterns, long hold-off);",
             stamps_sent);
    $display("checked %0d dates, %0d field mismatches.", dates_checked, mismatches);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
